/* design/lebvf_pkg.sv */
// shared constants and character classes for the line edit buffer
package lebvf_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  typedef logic [7:0]        char_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam char_t CH_BS    = 8'h08;
  localparam char_t CH_NL    = 8'h0A;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_TILDE = 8'h7E;

  localparam cnt_t DEPTH_CNT = cnt_t'(LINE_DEPTH);

  function automatic logic is_vowel(input char_t c);
    return (c == "a") || (c == "e") || (c == "i") || (c == "o") || (c == "u") ||
           (c == "A") || (c == "E") || (c == "I") || (c == "O") || (c == "U");
  endfunction

  function automatic logic is_printable(input char_t c);
    return (c >= CH_SPACE) && (c <= CH_TILDE);
  endfunction

endpackage

/* design/line_edit_buffer_vowel_filter.sv */
// line edit buffer: echo, backspace and line replay with optional vowel filter
// printable or backspace: at most one result the cycle after accept (none if line full or empty)
// newline: echoes a newline, replays the stored bytes, then closes with a newline and tlast;
//   each stored byte takes a memory read, then a filter check on the registered read data
// a new item is taken only while the sequencer is idle and the output register can move
// reset clears fill count, filter flag, sequencer and output valid; line memory is not cleared
module line_edit_buffer_vowel_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  lebvf_pkg::char_t     in_tdata,   // [7:0] in_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output lebvf_pkg::char_t     out_tdata,  // [7:0] out_byte
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);
  import lebvf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CHK  = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  cnt_t       idx_r, idx_nxt;
  logic       filter_r;
  logic       out_valid_r, out_valid_nxt;
  char_t      out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;
  char_t      rd_data_r;
  char_t      mem [LINE_DEPTH];

  logic in_acc, out_free, mem_we, mem_re;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign mem_we     = in_acc && is_printable(in_tdata) && (cnt_r < DEPTH_CNT);
  assign mem_re     = (state_r == S_RD) && (idx_r < cnt_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tdata == CH_BS) begin
            if (cnt_r != '0) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = CH_BS;
              out_last_nxt  = 1'b1;
              cnt_nxt       = cnt_r - cnt_t'(1);
            end
          end else if (in_tdata == CH_NL) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = CH_NL;
            out_last_nxt  = 1'b0;
            idx_nxt       = '0;
            state_nxt     = S_RD;
          end else if (mem_we) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = in_tdata;
            out_last_nxt  = 1'b1;
            cnt_nxt       = cnt_r + cnt_t'(1);
          end
        end
      end
      S_RD: begin
        if (mem_re) begin
          idx_nxt   = idx_r + cnt_t'(1);
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_END;
        end
      end
      S_CHK: begin
        // filtered vowels are dropped without touching the output
        if (filter_r && is_vowel(rd_data_r)) begin
          state_nxt = S_RD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_data_r;
          out_last_nxt  = 1'b0;
          state_nxt     = S_RD;
        end
      end
      S_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = CH_NL;
          out_last_nxt  = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      filter_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        filter_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // line memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[ADDR_W-1:0]] <= in_tdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

endmodule
